// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL files.
// Each macro checks a property on the rising edge of clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sacl_pkg.sv =====
// ----------------------------------------------------------------------------
// sacl_pkg
// Constants for the set-associative cache lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package sacl_pkg;

  // Default geometry limits.
  localparam int DEF_MAX_SETS = 1024;
  localparam int DEF_MAX_WAYS = 8;

  // Fixed field widths.
  localparam int ADDR_W   = 32;
  localparam int LINE_LSB = 2;              // 4-byte lines
  localparam int TAG_W    = ADDR_W - LINE_LSB;
  localparam int CNT_W    = 32;
  localparam int WAY_O_W  = 3;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY   = 2'd2;

  localparam logic [3:0] RST_SET_BITS = 4'd10;
  localparam logic [3:0] RST_WAYS     = 4'd4;
  localparam logic       RST_POLICY   = 1'b0;

endpackage

`default_nettype wire

// ===== rtl/set_assoc_cache_lookup.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_lookup
// Set-associative cache lookup with LRU or round-robin replacement.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                   Direction  Handshake
//  item in   address_i                               in         start & !busy
//  result    hit_o way_o hit_count_o miss_count_o     out        result_valid_o
//  config    cfg_idx_i cfg_wdata_i                   in         cfg_we_i
//
//  An accepted item goes through these steps in order: read the set row, scan
//  each active way in turn through the shared tag/stamp compare unit, write the
//  row back, and return to idle, where the result word shows and the next word
//  can be taken; busy is already low then. After reset a clearing pass writes
//  every set row once, with busy high. The receiver cannot stall the result
//  strobe.
//
`default_nettype none

`include "assert_macros.svh"

module set_assoc_cache_lookup #(
  parameter int MAX_SETS = sacl_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS = sacl_pkg::DEF_MAX_WAYS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // item in
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [sacl_pkg::ADDR_W-1:0]      address_i,
  // result
  output logic                                  result_valid_o,
  output logic                                  hit_o,
  output logic [sacl_pkg::WAY_O_W-1:0]          way_o,
  output logic [sacl_pkg::CNT_W-1:0]            hit_count_o,
  output logic [sacl_pkg::CNT_W-1:0]            miss_count_o,
  // configuration
  input  wire logic                             cfg_we_i,
  input  wire logic [sacl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [sacl_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int MAX_BITS = $clog2(MAX_SETS + 1) - 1;   // floor(log2(MAX_SETS))
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int TAG_W    = sacl_pkg::TAG_W;
  localparam int CNT_W    = sacl_pkg::CNT_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [3:0] cfg_set_bits_q;
  logic [3:0] cfg_ways_q;
  logic       cfg_policy_rr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_set_bits_q  <= sacl_pkg::RST_SET_BITS;
      cfg_ways_q      <= sacl_pkg::RST_WAYS;
      cfg_policy_rr_q <= sacl_pkg::RST_POLICY;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sacl_pkg::REG_SET_BITS: cfg_set_bits_q  <= cfg_wdata_i[3:0];
        sacl_pkg::REG_WAYS:     cfg_ways_q      <= cfg_wdata_i[3:0];
        sacl_pkg::REG_POLICY:   cfg_policy_rr_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Saturate set bits to the memory depth; clamp ways to 1..MAX_WAYS.
  logic [4:0]       bits_eff;
  logic [4:0]       ways5;
  logic [WAY_W-1:0] last_way;

  always_comb begin
    if ({1'b0, cfg_set_bits_q} > 5'(MAX_BITS)) begin
      bits_eff = 5'(MAX_BITS);
    end else begin
      bits_eff = {1'b0, cfg_set_bits_q};
    end
    ways5 = {1'b0, cfg_ways_q};
    if (ways5 == 5'd0) begin
      last_way = '0;
    end else if (ways5 > 5'(MAX_WAYS)) begin
      last_way = WAY_W'(MAX_WAYS - 1);
    end else begin
      last_way = WAY_W'(ways5 - 5'd1);
    end
  end

  // Split the address: line number, set index (low bits), tag (bits above).
  logic [TAG_W-1:0] line_no;
  logic [SET_W-1:0] set_in;
  logic [TAG_W-1:0] tag_in;

  always_comb begin
    line_no = address_i[sacl_pkg::ADDR_W-1:sacl_pkg::LINE_LSB];
    set_in  = line_no[SET_W-1:0] & ~({SET_W{1'b1}} << bits_eff);
    tag_in  = line_no >> bits_eff;
  end

  // --------------------------------------------------------------------------
  // Set memories: one row per set holds all ways; round-robin pointer per set
  // --------------------------------------------------------------------------
  logic [MAX_WAYS-1:0]                 valid_mem [MAX_SETS];
  logic [MAX_WAYS-1:0][TAG_W-1:0]      tag_mem   [MAX_SETS];
  logic [MAX_WAYS-1:0][CNT_W-1:0]      stamp_mem [MAX_SETS];
  logic [WAY_W-1:0]                    rr_mem    [MAX_SETS];

  logic                                mem_we;
  logic [SET_W-1:0]                    mem_addr;
  logic [MAX_WAYS-1:0]                 valid_wr;
  logic [MAX_WAYS-1:0][TAG_W-1:0]      tag_wr;
  logic [MAX_WAYS-1:0][CNT_W-1:0]      stamp_wr;
  logic                                rr_we;
  logic [WAY_W-1:0]                    rr_wr;

  logic [MAX_WAYS-1:0]                 valid_row_q;
  logic [MAX_WAYS-1:0][TAG_W-1:0]      tag_row_q;
  logic [MAX_WAYS-1:0][CNT_W-1:0]      stamp_row_q;
  logic [WAY_W-1:0]                    rr_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      valid_mem[mem_addr] <= valid_wr;
      tag_mem[mem_addr]   <= tag_wr;
      stamp_mem[mem_addr] <= stamp_wr;
    end
    if (rr_we) begin
      rr_mem[mem_addr] <= rr_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    valid_row_q <= valid_mem[mem_addr];
    tag_row_q   <= tag_mem[mem_addr];
    stamp_row_q <= stamp_mem[mem_addr];
    rr_q        <= rr_mem[mem_addr];
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [SET_W-1:0]  clr_q, clr_d;
  logic [SET_W-1:0]  set_q, set_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic [WAY_W-1:0]  w_q, w_d;
  logic              hit_fnd_q, hit_fnd_d;
  logic [WAY_W-1:0]  hit_way_q, hit_way_d;
  logic              inv_fnd_q, inv_fnd_d;
  logic [WAY_W-1:0]  inv_way_q, inv_way_d;
  logic [CNT_W-1:0]  min_q, min_d;
  logic [WAY_W-1:0]  min_way_q, min_way_d;
  logic [WAY_W-1:0]  victim_q, victim_d;
  logic [CNT_W-1:0]  clock_q, clock_d;
  logic [CNT_W-1:0]  hits_q, hits_d;
  logic [CNT_W-1:0]  misses_q, misses_d;
  logic              res_vld_q, res_vld_d;
  logic              res_hit_q, res_hit_d;
  logic [sacl_pkg::WAY_O_W-1:0] res_way_q, res_way_d;

  // Shared compare unit: one way per cycle.
  logic             cur_valid;
  logic [TAG_W-1:0] cur_tag;
  logic [CNT_W-1:0] cur_stamp;
  logic             tag_eq;
  logic             stamp_lt;

  // Update-step helpers
  logic             upd_hit;
  logic [WAY_W-1:0] victim;
  logic [WAY_W-1:0] rr_cur;
  logic [31:0]      victim_ext;

  always_comb begin
    cur_valid = valid_row_q[w_q];
    cur_tag   = tag_row_q[w_q];
    cur_stamp = stamp_row_q[w_q];
    tag_eq    = cur_valid && (cur_tag == tag_q);
    stamp_lt  = cur_stamp < min_q;

    // Victim choice for the write-back step.
    upd_hit = hit_fnd_q;
    rr_cur  = (rr_q > last_way) ? '0 : rr_q;
    if (hit_fnd_q) begin
      victim = hit_way_q;
    end else if (cfg_policy_rr_q) begin
      victim = rr_cur;
    end else if (inv_fnd_q) begin
      victim = inv_way_q;
    end else begin
      victim = min_way_q;
    end
    victim_ext = 32'(victim);

    state_d   = state_q;
    clr_d     = clr_q;
    set_d     = set_q;
    tag_d     = tag_q;
    w_d       = w_q;
    hit_fnd_d = hit_fnd_q;
    hit_way_d = hit_way_q;
    inv_fnd_d = inv_fnd_q;
    inv_way_d = inv_way_q;
    min_d     = min_q;
    min_way_d = min_way_q;
    victim_d  = victim_q;
    clock_d   = clock_q;
    hits_d    = hits_q;
    misses_d  = misses_q;
    res_vld_d = 1'b0;
    res_hit_d = res_hit_q;
    res_way_d = res_way_q;

    mem_we   = 1'b0;
    mem_addr = set_q;
    valid_wr = valid_row_q;
    tag_wr   = tag_row_q;
    stamp_wr = stamp_row_q;
    rr_we    = 1'b0;
    rr_wr    = (rr_cur == last_way) ? '0 : rr_cur + WAY_W'(1);

    case (state_q)
      ST_CLEAR: begin
        // Zero one set row per cycle.
        mem_we   = 1'b1;
        rr_we    = 1'b1;
        mem_addr = clr_q;
        valid_wr = '0;
        tag_wr   = '0;
        stamp_wr = '0;
        rr_wr    = '0;
        clr_d    = clr_q + SET_W'(1);
        if (clr_q == SET_W'(MAX_SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          set_d   = set_in;
          tag_d   = tag_in;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        // Row read is in flight; arm the scan.
        w_d       = '0;
        hit_fnd_d = 1'b0;
        inv_fnd_d = 1'b0;
        state_d   = ST_SCAN;
      end
      ST_SCAN: begin
        if (!hit_fnd_q && tag_eq) begin
          hit_fnd_d = 1'b1;
          hit_way_d = w_q;
        end
        if (!inv_fnd_q && !cur_valid) begin
          inv_fnd_d = 1'b1;
          inv_way_d = w_q;
        end
        // Strict less-than keeps the lowest way on equal stamps.
        if ((w_q == '0) || stamp_lt) begin
          min_d     = cur_stamp;
          min_way_d = w_q;
        end
        if (w_q == last_way) begin
          state_d = ST_UPDATE;
        end else begin
          w_d = w_q + WAY_W'(1);
        end
      end
      ST_UPDATE: begin
        mem_we           = 1'b1;
        valid_wr[victim] = 1'b1;
        tag_wr[victim]   = tag_q;
        stamp_wr[victim] = clock_q;
        rr_we            = !upd_hit && cfg_policy_rr_q;
        if (upd_hit) begin
          hits_d = hits_q + CNT_W'(1);
        end else begin
          misses_d = misses_q + CNT_W'(1);
        end
        clock_d   = clock_q + CNT_W'(1);
        victim_d  = victim;
        res_vld_d = 1'b1;
        res_hit_d = upd_hit;
        res_way_d = victim_ext[sacl_pkg::WAY_O_W-1:0];
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      w_q       <= '0;
      hit_fnd_q <= 1'b0;
      inv_fnd_q <= 1'b0;
      clock_q   <= '0;
      hits_q    <= '0;
      misses_q  <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      w_q       <= w_d;
      hit_fnd_q <= hit_fnd_d;
      inv_fnd_q <= inv_fnd_d;
      clock_q   <= clock_d;
      hits_q    <= hits_d;
      misses_q  <= misses_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    set_q     <= set_d;
    tag_q     <= tag_d;
    hit_way_q <= hit_way_d;
    inv_way_q <= inv_way_d;
    min_q     <= min_d;
    min_way_q <= min_way_d;
    victim_q  <= victim_d;
    res_hit_q <= res_hit_d;
    res_way_q <= res_way_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = res_vld_q;
  assign hit_o          = res_hit_q;
  assign way_o          = res_way_q;
  assign hit_count_o    = hits_q;
  assign miss_count_o   = misses_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_NEXT(a_strobe_single, result_valid_o, !result_valid_o, "result strobe held")
  `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `ASSERT_SAME(a_hit_count, result_valid_o && hit_o, hit_count_o == $past(hit_count_o) + 32'd1, "hit count did not advance")
  `ASSERT_SAME(a_miss_count, result_valid_o && !hit_o, miss_count_o == $past(miss_count_o) + 32'd1, "miss count did not advance")
  `ASSERT_SAME(a_way_range, result_valid_o, victim_q <= last_way, "way outside active ways")

endmodule

`default_nettype wire
